@@ hdl/swas_pkg.sv @@
// swas_pkg: word types and constants for the stencil weighted attribute smoother
// used by swas_front, swas_back and stencil_weighted_attribute_smoother
package swas_pkg;

  typedef struct packed {
    logic              func;
    logic              smooth_point;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [15:0] coord_z;
    logic signed [15:0] attr_value;
    logic              last;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] smoothed_value;
    logic              was_coincident;
  } out_word_t;

  // classified word handed from front to back
  typedef struct packed {
    logic              is_center;
    logic              is_last;
    logic              smooth;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [15:0] coord_z;
    logic signed [15:0] attr_value;
  } fb_word_t;

  localparam logic       FUNC_CENTER  = 1'b0;
  localparam logic [1:0] MODE_UNIT    = 2'd0;
  localparam logic [1:0] MODE_INV     = 2'd1;
  localparam logic [1:0] MODE_INV_SQ  = 2'd2;
  localparam logic [1:0] MODE_SPARE   = 2'd3;
  localparam logic [15:0] RELAX_ONE   = 16'd32768;
  localparam logic [15:0] RELAX_RESET = 16'd3277;
  localparam logic       REG_RELAX    = 1'b0;
  localparam logic       REG_MODE     = 1'b1;

endpackage

@@ hdl/swas_front.sv @@
// swas_front: input acceptance, word classification and a four-entry queue
// depends on swas_pkg
module swas_front
  import swas_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      q_valid,
  output fb_word_t  q_word,
  input  logic      q_pop
);

  fb_word_t   mem [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] fill;
  logic       push;
  fb_word_t   cls;

  assign in_stall = (fill == 3'd4);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill != 3'd0);
  assign q_word   = mem[rd_ptr];

  always_comb begin
    cls.is_center  = (in_data.func == FUNC_CENTER);
    cls.is_last    = in_data.last;
    cls.smooth     = in_data.smooth_point;
    cls.coord_x    = in_data.coord_x;
    cls.coord_y    = in_data.coord_y;
    cls.coord_z    = in_data.coord_z;
    cls.attr_value = in_data.attr_value;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      fill   <= 3'd0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 2'd1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      if (push && !q_pop) begin
        fill <= fill + 3'd1;
      end else if (!push && q_pop) begin
        fill <= fill - 3'd1;
      end
    end
  end

endmodule

@@ hdl/swas_back.sv @@
// swas_back: stencil accumulation, serial divider, serial square root and blend
// depends on swas_pkg
module swas_back
  import swas_pkg::*;
#(
  parameter int MAX_NEIGHBORS = 64
)
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  fb_word_t   q_word,
  output logic       q_pop,
  input  logic [15:0] relax_factor,
  input  logic [1:0] weight_mode,
  output logic       out_valid,
  input  logic       out_stall,
  output out_word_t  out_data
);

  localparam int CW = $clog2(MAX_NEIGHBORS + 1);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_SQ0  = 5'd1;
  localparam logic [4:0] S_SQ1  = 5'd2;
  localparam logic [4:0] S_SQ2  = 5'd3;
  localparam logic [4:0] S_SQ3  = 5'd4;
  localparam logic [4:0] S_CLS  = 5'd5;
  localparam logic [4:0] S_DIV  = 5'd6;
  localparam logic [4:0] S_SQRT = 5'd7;
  localparam logic [4:0] S_WV   = 5'd8;
  localparam logic [4:0] S_ACC  = 5'd9;
  localparam logic [4:0] S_FIN  = 5'd10;
  localparam logic [4:0] S_BL0  = 5'd11;
  localparam logic [4:0] S_BL1  = 5'd12;
  localparam logic [4:0] S_BL2  = 5'd13;
  localparam logic [4:0] S_OUT  = 5'd14;

  localparam logic [1:0] DK_INV_SQ = 2'd0;
  localparam logic [1:0] DK_INV    = 2'd1;
  localparam logic [1:0] DK_AVG    = 2'd2;

  logic [4:0]          state;
  fb_word_t            cur;
  logic signed [15:0]  cx, cy, cz, cv;
  logic                smooth_en;
  logic signed [55:0]  wsum;
  logic [39:0]         wtot;
  logic                coin_seen;
  logic signed [15:0]  coin_val;
  logic [CW-1:0]       count;
  logic [33:0]         d2;
  logic signed [52:0]  prod;
  logic [32:0]         w;
  logic [71:0]         dvd;
  logic [71:0]         quo;
  logic [39:0]         rem;
  logic [39:0]         dvsr;
  logic [6:0]          steps;
  logic [1:0]          dkind;
  logic [63:0]         sx;
  logic [34:0]         srem;
  logic [31:0]         root;
  logic                neg;
  logic signed [34:0]  avg;
  logic signed [49:0]  acc;
  logic signed [15:0]  res;
  logic                res_coin;

  logic signed [34:0]  mul_a;
  logic signed [17:0]  mul_b;
  logic signed [16:0]  dx, dy, dz;
  logic [15:0]         rc;
  logic [1:0]          mode_eff;
  logic [40:0]         rem_sh;
  logic                dge;
  logic [39:0]         rem_nx;
  logic [71:0]         quo_nx;
  logic [36:0]         srem_sh;
  logic [36:0]         trial;
  logic                sge;
  logic [31:0]         root_nx;
  logic [34:0]         qmag;
  logic [54:0]         mag;
  logic signed [49:0]  num;
  logic signed [18:0]  shr;
  logic                load_out;

  assign dx = {cur.coord_x[15], cur.coord_x} - {cx[15], cx};
  assign dy = {cur.coord_y[15], cur.coord_y} - {cy[15], cy};
  assign dz = {cur.coord_z[15], cur.coord_z} - {cz[15], cz};
  assign rc = (relax_factor > RELAX_ONE) ? RELAX_ONE : relax_factor;
  assign mode_eff = (weight_mode == MODE_SPARE) ? MODE_INV_SQ : weight_mode;
  assign q_pop = (state == S_IDLE) && q_valid;
  assign load_out = (state == S_OUT) && (!out_valid || !out_stall);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_SQ0: begin
        mul_a = 35'(dx);
        mul_b = 18'(dx);
      end
      S_SQ1: begin
        mul_a = 35'(dy);
        mul_b = 18'(dy);
      end
      S_SQ2: begin
        mul_a = 35'(dz);
        mul_b = 18'(dz);
      end
      S_WV: begin
        mul_a = $signed({2'b00, w});
        mul_b = 18'(cur.attr_value);
      end
      S_BL0: begin
        mul_a = $signed({18'd0, 17'd32768 - {1'b0, rc}});
        mul_b = 18'(cv);
      end
      S_BL1: begin
        mul_a = avg;
        mul_b = $signed({2'b00, rc});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // one restoring divider step, one square root step, the wsum magnitude and the blend rounding
  always_comb begin
    rem_sh  = {rem, dvd[71]};
    dge     = (rem_sh >= {1'b0, dvsr});
    rem_nx  = dge ? 40'(rem_sh - {1'b0, dvsr}) : rem_sh[39:0];
    quo_nx  = {quo[70:0], dge};
    srem_sh = {srem, sx[63:62]};
    trial   = {3'd0, root, 2'b01};
    sge     = (srem_sh >= trial);
    root_nx = {root[30:0], sge};
    qmag    = quo_nx[34:0];
    mag     = wsum[55] ? 55'(-wsum) : wsum[54:0];
    num     = acc + 50'(prod) + 50'sd1073741824;
    shr     = num[49:31];
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cx        <= '0;
      cy        <= '0;
      cz        <= '0;
      cv        <= '0;
      smooth_en <= 1'b0;
      wsum      <= '0;
      wtot      <= '0;
      coin_seen <= 1'b0;
      coin_val  <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur <= q_word;
            if (q_word.is_center) begin
              cx        <= q_word.coord_x;
              cy        <= q_word.coord_y;
              cz        <= q_word.coord_z;
              cv        <= q_word.attr_value;
              smooth_en <= q_word.smooth;
              wsum      <= '0;
              wtot      <= '0;
              coin_seen <= 1'b0;
              coin_val  <= '0;
              count     <= '0;
              state     <= q_word.is_last ? S_FIN : S_IDLE;
            end else if (count < CW'(MAX_NEIGHBORS)) begin
              state <= S_SQ0;
            end else begin
              state <= q_word.is_last ? S_FIN : S_IDLE;
            end
          end
        end
        S_SQ0: begin
          state <= S_SQ1;
        end
        S_SQ1: begin
          d2    <= prod[33:0];
          state <= S_SQ2;
        end
        S_SQ2: begin
          d2    <= d2 + prod[33:0];
          state <= S_SQ3;
        end
        S_SQ3: begin
          d2    <= d2 + prod[33:0];
          state <= S_CLS;
        end
        S_CLS: begin
          count <= count + CW'(1);
          rem   <= '0;
          quo   <= '0;
          dvd   <= {1'b1, 71'd0};
          dvsr  <= {6'd0, d2};
          if (d2 == '0) begin
            coin_seen <= 1'b1;
            coin_val  <= cur.attr_value;
            state     <= cur.is_last ? S_FIN : S_IDLE;
          end else if (mode_eff == MODE_UNIT || (mode_eff == MODE_INV && d2 == 34'd1)) begin
            w     <= 33'h1_0000_0000;
            state <= S_WV;
          end else if (mode_eff == MODE_INV) begin
            steps <= 7'd65;
            dkind <= DK_INV;
            state <= S_DIV;
          end else begin
            steps <= 7'd33;
            dkind <= DK_INV_SQ;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem   <= rem_nx;
          quo   <= quo_nx;
          dvd   <= {dvd[70:0], 1'b0};
          if (steps == 7'd1) begin
            case (dkind)
              DK_INV: begin
                sx    <= quo_nx[63:0];
                srem  <= '0;
                root  <= '0;
                steps <= 7'd32;
                state <= S_SQRT;
              end
              DK_AVG: begin
                if (neg) begin
                  avg <= (rem_nx != '0) ? -$signed(qmag) - 35'sd1 : -$signed(qmag);
                end else begin
                  avg <= $signed(qmag);
                end
                state <= S_BL0;
              end
              default: begin
                w     <= (quo_nx[32:0] == '0) ? 33'd1 : quo_nx[32:0];
                state <= S_WV;
              end
            endcase
          end else begin
            steps <= steps - 7'd1;
          end
        end
        S_SQRT: begin
          srem  <= sge ? 35'(srem_sh - trial) : srem_sh[34:0];
          root  <= root_nx;
          sx    <= {sx[61:0], 2'b00};
          steps <= steps - 7'd1;
          if (steps == 7'd1) begin
            w     <= (root_nx == '0) ? 33'd1 : {1'b0, root_nx};
            state <= S_WV;
          end
        end
        S_WV: begin
          state <= S_ACC;
        end
        S_ACC: begin
          wsum  <= wsum + 56'(prod);
          wtot  <= wtot + 40'(w);
          state <= cur.is_last ? S_FIN : S_IDLE;
        end
        S_FIN: begin
          res_coin <= smooth_en && coin_seen;
          if (!smooth_en) begin
            res   <= cv;
            state <= S_OUT;
          end else if (coin_seen) begin
            avg   <= $signed({{3{coin_val[15]}}, coin_val, 16'd0});
            state <= S_BL0;
          end else if (wtot == '0) begin
            avg   <= '0;
            state <= S_BL0;
          end else begin
            neg   <= wsum[55];
            rem   <= '0;
            quo   <= '0;
            dvd   <= {mag, 17'd0};
            dvsr  <= wtot;
            steps <= 7'd71;
            dkind <= DK_AVG;
            state <= S_DIV;
          end
        end
        S_BL0: begin
          state <= S_BL1;
        end
        S_BL1: begin
          acc   <= 50'(prod) <<< 16;
          state <= S_BL2;
        end
        S_BL2: begin
          if (shr > 19'sd32767) begin
            res <= 16'sh7fff;
          end else if (shr < -19'sd32768) begin
            res <= 16'sh8000;
          end else begin
            res <= shr[15:0];
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (load_out) begin
            out_data.smoothed_value <= res;
            out_data.was_coincident <= res_coin;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_NEIGHBORS))
    else $error("neighbour count beyond limit");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load_out |=> out_valid)
    else $error("result word not presented");

  a_weight_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_ACC |-> w != '0)
    else $error("zero weight accumulated");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> state != S_OUT)
    else $error("pop while result pending");

endmodule

@@ hdl/stencil_weighted_attribute_smoother.sv @@
// stencil_weighted_attribute_smoother: top level, register port, front and back
// back, one word at a time: centre latched; neighbour weighted unit, 1/d^2 or 1/d,
// none if coincident; closing word may add the 71-step average divide, then the blend
// unless smoothing is off; words wait in the four-word front queue while the back is busy
// reset: synchronous, clears queue, accumulators and restores register defaults
module stencil_weighted_attribute_smoother
  import swas_pkg::*;
#(
  parameter int MAX_NEIGHBORS = 64
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] relax_factor;
  logic [1:0]  weight_mode;
  logic        q_valid;
  logic        q_pop;
  fb_word_t    q_word;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MODE) ? {30'd0, weight_mode} : {16'd0, relax_factor};

  always_ff @(posedge clk) begin
    if (rst) begin
      relax_factor <= RELAX_RESET;
      weight_mode  <= MODE_INV_SQ;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_RELAX) begin
        relax_factor <= pwdata[15:0];
      end else begin
        weight_mode <= pwdata[1:0];
      end
    end
  end

  swas_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_word   (q_word),
    .q_pop    (q_pop)
  );

  swas_back #(
    .MAX_NEIGHBORS (MAX_NEIGHBORS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_word       (q_word),
    .q_pop        (q_pop),
    .relax_factor (relax_factor),
    .weight_mode  (weight_mode),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data)
  );

endmodule
